// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define EFD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// Same-cycle implication that is also checked during reset.
`define EFD_ASSERT_RST(label, clk, ante, cons) \
	label: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

// ----- hdl/efd_pkg.sv -----
// ----------------------------------------------------------------------------
// efd_pkg: shared types and constants of the escaped frame deframer
// Framing symbols, class codes, and the structs passed between front end,
// descriptor queue and back end.
// ----------------------------------------------------------------------------
package efd_pkg;

	// Framing symbols on the serial link.
	localparam logic [7:0] SYM_START = 8'h5E;
	localparam logic [7:0] SYM_END   = 8'h24;
	localparam logic [7:0] SYM_ABORT = 8'h21;
	localparam logic [7:0] SYM_ESC   = 8'h5C;

	// First bytes that select a frame class.
	localparam logic [7:0] SYM_INFO = 8'h4E;
	localparam logic [7:0] SYM_WARN = 8'h41;
	localparam logic [7:0] SYM_ERR  = 8'h45;

	// Frame class codes.
	localparam logic [1:0] CLS_DATA = 2'd0;
	localparam logic [1:0] CLS_INFO = 2'd1;
	localparam logic [1:0] CLS_WARN = 2'd2;
	localparam logic [1:0] CLS_ERR  = 2'd3;

	// Frame length counter and memory address, sized for a frame depth of up to 64.
	localparam int LEN_W  = 7;
	localparam int ADDR_W = 7;

	// Memory write from the front end.
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_t;

	// One completed frame waiting to be drained.
	typedef struct packed {
		logic             bank;
		logic [LEN_W-1:0] len;
		logic [1:0]       cls;
	} desc_t;

	// Descriptor push from the front end into the queue.
	typedef struct packed {
		logic  valid;
		desc_t desc;
	} push_t;

	// Back end hands a buffer bank back to the front end.
	typedef struct packed {
		logic valid;
		logic bank;
	} rel_t;

	function automatic logic [1:0] class_of(input logic [7:0] first);
		logic [1:0] cls;
		case (first)
			SYM_INFO: cls = CLS_INFO;
			SYM_WARN: cls = CLS_WARN;
			SYM_ERR:  cls = CLS_ERR;
			default:  cls = CLS_DATA;
		endcase
		return cls;
	endfunction

endpackage

// ----- hdl/efd_front.sv -----
// ----------------------------------------------------------------------------
// efd_front: receive side of the deframer
// Classifies each received byte, tracks the frame state, writes unescaped
// bytes into the current buffer bank and pushes a descriptor on frame end.
// ----------------------------------------------------------------------------
module efd_front #(
	parameter int FRAME_DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       rx_byte,
	output efd_pkg::wr_t     wr,
	output efd_pkg::push_t   push,
	input  efd_pkg::rel_t    rel
);

	localparam int IDX_W = $clog2(FRAME_DEPTH);
	localparam logic [efd_pkg::LEN_W-1:0] DEPTH_LEN = efd_pkg::LEN_W'(FRAME_DEPTH);

	logic                      in_frame_q;
	logic                      esc_q;
	logic [efd_pkg::LEN_W-1:0] len_q;
	logic [1:0]                cls_q;
	logic                      bank_q;
	logic [1:0]                busy_q;
	logic [1:0]                busy_d;

	logic       accept;
	logic       is_data;
	logic       do_write;
	logic       do_emit;
	logic [7:0] data_byte;

	// A frame in progress waits while its bank is still being drained.
	assign in_stall = in_frame_q && busy_q[bank_q];
	assign accept   = in_valid && !in_stall;

	always_comb begin
		case (rx_byte)
			efd_pkg::SYM_START, efd_pkg::SYM_END,
			efd_pkg::SYM_ABORT, efd_pkg::SYM_ESC: is_data = 1'b0;
			default: is_data = 1'b1;
		endcase
	end

	assign data_byte = esc_q ? ~rx_byte : rx_byte;
	assign do_write  = accept && is_data && in_frame_q && (len_q != DEPTH_LEN);
	assign do_emit   = accept && (rx_byte == efd_pkg::SYM_END) && in_frame_q &&
	                   (len_q != '0);

	assign wr.en   = do_write;
	assign wr.addr = efd_pkg::ADDR_W'({bank_q, len_q[IDX_W-1:0]});
	assign wr.data = data_byte;

	assign push.valid     = do_emit;
	assign push.desc.bank = bank_q;
	assign push.desc.len  = len_q;
	assign push.desc.cls  = cls_q;

	always_comb begin
		busy_d = busy_q;
		if (rel.valid) begin
			busy_d[rel.bank] = 1'b0;
		end
		if (do_emit) begin
			busy_d[bank_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			len_q      <= '0;
			cls_q      <= efd_pkg::CLS_DATA;
			bank_q     <= 1'b0;
			busy_q     <= '0;
		end else begin
			busy_q <= busy_d;
			if (do_emit) begin
				bank_q <= ~bank_q;
			end
			if (accept) begin
				case (rx_byte)
					efd_pkg::SYM_START: begin
						in_frame_q <= 1'b1;
						esc_q      <= 1'b0;
						len_q      <= '0;
					end
					efd_pkg::SYM_END: begin
						in_frame_q <= 1'b0;
					end
					efd_pkg::SYM_ABORT: begin
						in_frame_q <= 1'b0;
					end
					efd_pkg::SYM_ESC: begin
						esc_q <= 1'b1;
					end
					default: begin
						if (in_frame_q) begin
							if (len_q == DEPTH_LEN) begin
								in_frame_q <= 1'b0;
							end else begin
								esc_q <= 1'b0;
								len_q <= len_q + 1'b1;
								if (len_q == '0) begin
									cls_q <= efd_pkg::class_of(data_byte);
								end
							end
						end
					end
				endcase
			end
		end
	end

endmodule

// ----- hdl/efd_queue.sv -----
// ----------------------------------------------------------------------------
// efd_queue: two-entry descriptor queue
// Holds completed frame descriptors between the front end and the back end.
// ----------------------------------------------------------------------------
module efd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  efd_pkg::push_t   push,
	input  logic             pop,
	output efd_pkg::desc_t   head,
	output logic             empty
);

	efd_pkg::desc_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign head  = entry_q[rd_ptr_q];
	assign empty = (count_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push.valid) begin
			entry_q[wr_ptr_q] <= push.desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push.valid, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hdl/efd_back.sv -----
// ----------------------------------------------------------------------------
// efd_back: transmit side of the deframer
// Owns the two-bank frame memory, drains one descriptor at a time and
// presents the bytes through a registered output stage.
// ----------------------------------------------------------------------------
module efd_back #(
	parameter int FRAME_DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  efd_pkg::wr_t     wr,
	input  efd_pkg::desc_t   head,
	input  logic             q_empty,
	output logic             pop,
	output efd_pkg::rel_t    rel,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       frame_byte,
	output logic [1:0]       frame_class,
	output logic             frame_last
);

	localparam int IDX_W = $clog2(FRAME_DEPTH);
	localparam int AW    = IDX_W + 1;

	// Each bank spans a full power-of-two window so that {bank, index} stays in range.
	logic [7:0] mem_q [2**AW];

	logic                      act_q;
	logic                      bank_q;
	logic [efd_pkg::LEN_W-1:0] len_q;
	logic [efd_pkg::LEN_W-1:0] idx_q;
	logic [1:0]                cls_q;

	logic       s1_valid_s1;
	logic [7:0] rdata_s1;
	logic       last_s1;
	logic [1:0] cls_s1;

	logic       out_valid_q;
	logic [7:0] byte_q;
	logic [1:0] class_q;
	logic       last_q;

	logic          move;
	logic          issue;
	logic          rd_last;
	logic [AW-1:0] rd_addr;

	assign pop     = !act_q && !q_empty;
	assign move    = s1_valid_s1 && (!out_valid_q || !out_stall);
	assign issue   = act_q && (!s1_valid_s1 || move);
	assign rd_last = (idx_q + 1'b1) == len_q;
	assign rd_addr = {bank_q, idx_q[IDX_W-1:0]};

	assign rel.valid = issue && rd_last;
	assign rel.bank  = bank_q;

	assign out_valid   = out_valid_q;
	assign frame_byte  = byte_q;
	assign frame_class = class_q;
	assign frame_last  = last_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr[AW-1:0]] <= wr.data;
		end
		if (issue) begin
			rdata_s1 <= mem_q[rd_addr];
			last_s1  <= rd_last;
			cls_s1   <= cls_q;
		end
		if (move) begin
			byte_q  <= rdata_s1;
			class_q <= cls_s1;
			last_q  <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q       <= 1'b0;
			bank_q      <= 1'b0;
			len_q       <= '0;
			idx_q       <= '0;
			cls_q       <= efd_pkg::CLS_DATA;
			s1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				act_q  <= 1'b1;
				bank_q <= head.bank;
				len_q  <= head.len;
				cls_q  <= head.cls;
				idx_q  <= '0;
			end else if (issue) begin
				idx_q <= idx_q + 1'b1;
				if (rd_last) begin
					act_q <= 1'b0;
				end
			end

			if (issue) begin
				s1_valid_s1 <= 1'b1;
			end else if (move) begin
				s1_valid_s1 <= 1'b0;
			end

			if (move) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hdl/escaped_frame_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// escaped_frame_deframer_unit: byte-stuffed frame deframer
// Takes received serial bytes and emits the bytes of each completed frame.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall, rx_byte) takes one received byte per
// beat. '^' opens a frame, '!' aborts it, '\' makes the next data byte be stored
// complemented, and '$' closes it. The output channel (out_valid, out_stall,
// frame_byte, frame_class, frame_last) gives one frame byte per beat, with the
// class of the frame's first byte on every beat and frame_last on the final one.
// Empty, aborted and overflowed frames produce no beats.
// The input takes one byte per cycle while in_stall is low. Frames are buffered
// in two memory banks, so a new frame is received while the previous one drains.
// in_stall rises only while a frame is open in a bank whose earlier frame is not
// yet read out. A closed frame waits in the descriptor queue, then its bytes pass
// the read stage and output register one per cycle while out_stall is low; the
// frame memory's single read port sets the drain. When out_stall is high the
// output beat holds, one more byte waits in the read stage and further reads
// pause. Reset clears all frame and queue state at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module escaped_frame_deframer_unit #(
	parameter int FRAME_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] frame_byte,
	output logic [1:0] frame_class,
	output logic       frame_last
);

	// Write path from the front end into the frame memory.
	efd_pkg::wr_t   wr;
	// Completed frame descriptors, and the head of the queue.
	efd_pkg::push_t push;
	efd_pkg::desc_t head;
	logic           q_empty;
	logic           pop;
	// A bank goes back to the front end once its last byte has been read.
	efd_pkg::rel_t  rel;

	efd_front #(
		.FRAME_DEPTH(FRAME_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.wr       (wr),
		.push     (push),
		.rel      (rel)
	);

	efd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.empty  (q_empty)
	);

	efd_back #(
		.FRAME_DEPTH(FRAME_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr          (wr),
		.head        (head),
		.q_empty     (q_empty),
		.pop         (pop),
		.rel         (rel),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.frame_byte  (frame_byte),
		.frame_class (frame_class),
		.frame_last  (frame_last)
	);

endmodule

// ----- hdl/efd_checker.sv -----
// ----------------------------------------------------------------------------
// efd_checker: port-level checks of the deframer
// Watches the top-level ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module efd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] frame_byte,
	input logic [1:0] frame_class,
	input logic       frame_last
);

	logic out_hold;
	logic out_mid;

	assign out_hold = out_valid && out_stall;
	assign out_mid  = out_valid && !out_stall && !frame_last;

	// A stalled beat stays offered.
	`EFD_ASSERT_NXT(a_out_valid_hold, clk, arst_n, out_hold, out_valid)
	// A stalled beat keeps its payload.
	`EFD_ASSERT_NXT(a_out_data_hold, clk, arst_n, out_hold,
		$stable(frame_byte) && $stable(frame_class) && $stable(frame_last))
	// No beat is offered while reset is held.
	`EFD_ASSERT_RST(a_no_beat_in_reset, clk, !arst_n, !out_valid)
	// Back-to-back beats of one frame carry the same class.
	`EFD_ASSERT_NXT(a_class_in_frame, clk, arst_n, out_mid,
		!out_valid || (frame_class == $past(frame_class)))

endmodule

bind escaped_frame_deframer_unit efd_checker u_efd_checker (.*);
